/* src/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int TAG_W  = 64;
	localparam int STAT_W = 3;
	localparam int REC_W  = KEY_W + TAG_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT    = 2'd0,
		FN_DELETE    = 2'd1,
		FN_DUMP_ASC  = 2'd2,
		FN_DUMP_DESC = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// compare unit result: stored key against request key
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// record store port control
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} ram_ctl_t;

endpackage

/* src/skt_if.sv */
// ----------------------------------------------------------------------------
// skt_if
// Valid/ready channels of the sorted key table: request and response.
// ----------------------------------------------------------------------------
interface skt_req_if;
	logic                              valid;
	logic                              ready;
	logic [skt_pkg::FUNC_W-1:0]        func;
	logic signed [skt_pkg::KEY_W-1:0]  key;
	logic [skt_pkg::TAG_W-1:0]         tag;

	modport source (output valid, func, key, tag, input ready);
	modport sink   (input valid, func, key, tag, output ready);
endinterface

interface skt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [skt_pkg::STAT_W-1:0]        status;
	logic signed [skt_pkg::KEY_W-1:0]  out_key;
	logic [skt_pkg::TAG_W-1:0]         out_tag;
	logic                              last;

	modport source (output valid, status, out_key, out_tag, last, input ready);
	modport sink   (input valid, status, out_key, out_tag, last, output ready);
endinterface

/* src/skt_ram.sv */
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/skt_cmp.sv */
// ----------------------------------------------------------------------------
// skt_cmp
// Shared key comparator: signed less-than and equality.
// ----------------------------------------------------------------------------
module skt_cmp (
	input  logic signed [skt_pkg::KEY_W-1:0] a,
	input  logic signed [skt_pkg::KEY_W-1:0] b,
	output skt_pkg::cmp_res_t                res
);

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

/* src/skt_seq.sv */
// ----------------------------------------------------------------------------
// skt_seq
// Sequencer of the sorted key table: scan, shift, dump and response register.
// ----------------------------------------------------------------------------
module skt_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	skt_req_if.sink                           req,
	skt_rsp_if.source                         rsp,
	output skt_pkg::ram_ctl_t                 ram_ctl,
	output logic [skt_pkg::REC_W-1:0]         ram_wr_data,
	input  logic [skt_pkg::REC_W-1:0]         ram_rd_data,
	output logic signed [skt_pkg::KEY_W-1:0]  cmp_a,
	output logic signed [skt_pkg::KEY_W-1:0]  cmp_b,
	input  skt_pkg::cmp_res_t                 cmp_res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP,
		S_DREAD,
		S_DLOAD
	} state_t;

	localparam logic [skt_pkg::CNT_W-1:0] ONE  = skt_pkg::CNT_W'(1);
	localparam logic [skt_pkg::CNT_W-1:0] FULL = skt_pkg::CNT_W'(skt_pkg::CAPACITY);

	state_t                             state_q;
	skt_pkg::func_t                     func_q;
	logic signed [skt_pkg::KEY_W-1:0]   key_q;
	logic [skt_pkg::TAG_W-1:0]          tag_q;
	logic [skt_pkg::CNT_W-1:0]          cnt_q;
	logic [skt_pkg::CNT_W-1:0]          addr_q;
	logic [skt_pkg::CNT_W-1:0]          pos_q;
	logic [skt_pkg::CNT_W-1:0]          rem_q;
	skt_pkg::status_t                   st_q;
	logic                               vld_s1;
	logic [skt_pkg::CNT_W-1:0]          idx_s1;

	logic                               ovld_q;
	skt_pkg::status_t                   ostat_q;
	logic signed [skt_pkg::KEY_W-1:0]   okey_q;
	logic [skt_pkg::TAG_W-1:0]          otag_q;
	logic                               olast_q;

	logic                               slot_free;
	logic                               is_ins;
	logic                               is_asc;
	logic                               issue_scan;
	logic                               issue_shift;
	logic                               issue_dump;
	logic                               scan_hit;
	logic                               scan_end;
	logic                               out_load;
	logic [skt_pkg::CNT_W-1:0]          wr_idx;

	assign slot_free = !ovld_q || rsp.ready;
	assign is_ins    = (func_q == skt_pkg::FN_INSERT);
	assign is_asc    = (func_q == skt_pkg::FN_DUMP_ASC);

	assign issue_scan  = (state_q == S_SCAN) && (addr_q < cnt_q);
	assign issue_shift = (state_q == S_SHIFT) && (rem_q != '0);
	assign issue_dump  = (state_q == S_DREAD) && slot_free;

	// insert stops at the first stored key not below the new one; delete at equality
	assign cmp_a    = ram_rd_data[skt_pkg::REC_W-1 -: skt_pkg::KEY_W];
	assign cmp_b    = key_q;
	assign scan_hit = vld_s1 && (is_ins ? !cmp_res.lt : cmp_res.eq);
	assign scan_end = scan_hit || (!vld_s1 && !issue_scan);

	assign out_load = ((state_q == S_RESP) && slot_free) || (state_q == S_DLOAD);

	always_comb begin
		ram_ctl.rd_en   = issue_scan || issue_shift || issue_dump;
		ram_ctl.rd_addr = addr_q[skt_pkg::IDX_W-1:0];
		ram_ctl.wr_en   = 1'b0;
		wr_idx          = pos_q;
		ram_wr_data     = {key_q, tag_q};
		if (state_q == S_SHIFT) begin
			if (vld_s1) begin
				ram_ctl.wr_en = 1'b1;
				wr_idx        = is_ins ? idx_s1 + ONE : idx_s1 - ONE;
				ram_wr_data   = ram_rd_data;
			end else if (!issue_shift && is_ins) begin
				// shift finished: drop the new record into the gap
				ram_ctl.wr_en = 1'b1;
			end
		end
		ram_ctl.wr_addr = wr_idx[skt_pkg::IDX_W-1:0];
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = ovld_q;
	assign rsp.status  = ostat_q;
	assign rsp.out_key = okey_q;
	assign rsp.out_tag = otag_q;
	assign rsp.last    = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= skt_pkg::FN_INSERT;
			key_q   <= '0;
			tag_q   <= '0;
			cnt_q   <= '0;
			addr_q  <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
			st_q    <= skt_pkg::ST_OK;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			ovld_q  <= 1'b0;
			ostat_q <= skt_pkg::ST_OK;
			okey_q  <= '0;
			otag_q  <= '0;
			olast_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q <= skt_pkg::func_t'(req.func);
						key_q  <= req.key;
						tag_q  <= req.tag;
						vld_s1 <= 1'b0;
						if (req.func == skt_pkg::FN_INSERT || req.func == skt_pkg::FN_DELETE) begin
							addr_q  <= '0;
							state_q <= S_SCAN;
						end else if (cnt_q == '0) begin
							st_q    <= skt_pkg::ST_EMPTY;
							state_q <= S_RESP;
						end else begin
							rem_q   <= cnt_q;
							addr_q  <= (req.func == skt_pkg::FN_DUMP_ASC) ? '0 : cnt_q - ONE;
							state_q <= S_DREAD;
						end
					end
				end

				S_SCAN: begin
					idx_s1 <= addr_q;
					if (scan_end) begin
						// a read still in flight is dropped
						vld_s1 <= 1'b0;
						if (is_ins) begin
							if (scan_hit && cmp_res.eq) begin
								st_q    <= skt_pkg::ST_DUP;
								state_q <= S_RESP;
							end else if (cnt_q == FULL) begin
								st_q    <= skt_pkg::ST_FULL;
								state_q <= S_RESP;
							end else begin
								pos_q   <= scan_hit ? idx_s1 : cnt_q;
								rem_q   <= cnt_q - (scan_hit ? idx_s1 : cnt_q);
								addr_q  <= cnt_q - ONE;
								state_q <= S_SHIFT;
							end
						end else begin
							if (!scan_hit) begin
								st_q    <= skt_pkg::ST_NOTFOUND;
								state_q <= S_RESP;
							end else begin
								rem_q   <= cnt_q - ONE - idx_s1;
								addr_q  <= idx_s1 + ONE;
								state_q <= S_SHIFT;
							end
						end
					end else begin
						vld_s1 <= issue_scan;
						if (issue_scan) begin
							addr_q <= addr_q + ONE;
						end
					end
				end

				S_SHIFT: begin
					if (issue_shift) begin
						rem_q  <= rem_q - ONE;
						addr_q <= is_ins ? addr_q - ONE : addr_q + ONE;
					end
					vld_s1 <= issue_shift;
					idx_s1 <= addr_q;
					if (!issue_shift && !vld_s1) begin
						cnt_q   <= is_ins ? cnt_q + ONE : cnt_q - ONE;
						st_q    <= skt_pkg::ST_OK;
						state_q <= S_RESP;
					end
				end

				S_RESP: begin
					if (slot_free) begin
						ostat_q <= st_q;
						okey_q  <= '0;
						otag_q  <= '0;
						olast_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end

				S_DREAD: begin
					if (issue_dump) begin
						addr_q  <= is_asc ? addr_q + ONE : addr_q - ONE;
						rem_q   <= rem_q - ONE;
						state_q <= S_DLOAD;
					end
				end

				S_DLOAD: begin
					ostat_q <= skt_pkg::ST_OK;
					okey_q  <= ram_rd_data[skt_pkg::REC_W-1 -: skt_pkg::KEY_W];
					otag_q  <= ram_rd_data[skt_pkg::TAG_W-1:0];
					olast_q <= (rem_q == '0);
					state_q <= (rem_q == '0) ? S_IDLE : S_DREAD;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("entry count beyond capacity");

	a_rd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.rd_en |-> (addr_q < cnt_q))
		else $error("read of an entry outside the table");

	a_wr_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.wr_en |-> (state_q == S_SHIFT))
		else $error("record store written outside a shift");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ovld_q || rsp.ready))
		else $error("pending result overwritten");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DLOAD && rem_q == '0) |=> (state_q == S_IDLE && olast_q))
		else $error("dump did not close with last");
`endif

endmodule

/* src/sorted_key_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Bounded table of (key, tag) records kept in ascending signed key order,
// with insert, delete and ascending/descending dump.
// ----------------------------------------------------------------------------
//  channel  dir  fields                        transfer
//  req      in   func, key, tag                one per operation
//  rsp      out  status, out_key, out_tag,     one per result, last on final
//                last
//
//  Insert/delete: accept, a scan of the stored keys (RAM read, compare in the
//  cycle after), a shift of the records that move, then the response.
//  Dump: accept, then per record a RAM read once the response slot is free,
//  then a response register load.
//  Reset clears the entry count and the sequencer registers; the record RAM
//  needs no clearing pass.
//  A stalled rsp holds the sequencer; req is taken only while it is idle.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
	input  logic      clk,
	input  logic      arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	skt_pkg::ram_ctl_t                 ram_ctl;
	logic [skt_pkg::REC_W-1:0]         ram_wr_data;
	logic [skt_pkg::REC_W-1:0]         ram_rd_data;
	logic signed [skt_pkg::KEY_W-1:0]  cmp_a;
	logic signed [skt_pkg::KEY_W-1:0]  cmp_b;
	skt_pkg::cmp_res_t                 cmp_res;

	skt_ram #(
		.WIDTH (skt_pkg::REC_W),
		.DEPTH (skt_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_ctl.wr_en),
		.wr_addr (ram_ctl.wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (ram_ctl.rd_addr),
		.rd_data (ram_rd_data)
	);

	skt_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	skt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.ram_ctl     (ram_ctl),
		.ram_wr_data (ram_wr_data),
		.ram_rd_data (ram_rd_data),
		.cmp_a       (cmp_a),
		.cmp_b       (cmp_b),
		.cmp_res     (cmp_res)
	);

endmodule
